FILE: design/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;

  localparam int TAPS = 9;
  localparam logic [3:0] LAST_TAP = 4'd8;
  localparam logic [1:0] LAST_CH = 2'd2;
  localparam logic [21:0] ROOT_SAT = 22'd65280;
  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic div_init;
    logic div_step;
    logic tap_rd;
    logic tap_acc;
    logic sqx;
    logic sqy;
    logic root_init;
    logic root_step;
    logic rnd;
    logic fin;
    logic [3:0] tap;
    logic [1:0] ch;
    logic [2:0] bitn;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit;
  } ctl_sts_t;

  // row offset of a window tap: -1, 0, +1
  function automatic logic signed [1:0] tap_dy(input logic [3:0] tap);
    logic signed [1:0] r;
    case (tap)
      4'd0, 4'd1, 4'd2: r = -2'sd1;
      4'd3, 4'd4, 4'd5: r = 2'sd0;
      default: r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] tap_dx(input logic [3:0] tap);
    logic signed [1:0] r;
    case (tap)
      4'd0, 4'd3, 4'd6: r = -2'sd1;
      4'd1, 4'd4, 4'd7: r = 2'sd0;
      default: r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] tap_kx(input logic [3:0] tap);
    logic signed [2:0] r;
    case (tap)
      4'd0, 4'd6: r = -3'sd1;
      4'd3: r = -3'sd2;
      4'd2, 4'd8: r = 3'sd1;
      4'd5: r = 3'sd2;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] tap_ky(input logic [3:0] tap);
    logic signed [2:0] r;
    case (tap)
      4'd0, 4'd2: r = -3'sd1;
      4'd1: r = -3'sd2;
      4'd6, 4'd8: r = 3'sd1;
      4'd7: r = 3'sd2;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid / in_stall  opcode, in_red, in_green, in_blue
// out      out_valid/out_stall  out_red, out_green, out_blue, frame_last
// cfg      cfg_we               cfg_index, cfg_data
//
// one item at a time; an item that gives no result goes from START straight to FIN
// an item with a result runs through more states before FIN: the row/column
// divider (CW steps), nine history reads and a bit-serial root per channel
// rst is synchronous; history memory is not cleared
// a finished result waits in the output register while the next item is taken;
// a new result holds its item until the older one leaves
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [10:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic opcode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic frame_last
);

  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  sem_pkg::ctl_cmd_t cmd;
  sem_pkg::ctl_sts_t sts;

  sem_controller #(.CW(CW)) u_ctl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts(sts),
    .cmd(cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .opcode(opcode),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .cmd(cmd),
    .sts(sts),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .frame_last(frame_last)
  );

endmodule

FILE: design/sem_datapath.sv
`timescale 1ns / 1ps
module sem_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [10:0] cfg_data,
  input  logic opcode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  sem_pkg::ctl_cmd_t cmd,
  output sem_pkg::ctl_sts_t sts,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic frame_last
);

  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW = AW + 2;
  localparam int PW = ((CW > AW) ? CW : AW) + 3;

  logic [10:0] w_reg;
  logic [10:0] h_reg;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] total;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data;

  logic op_r;
  logic [23:0] live_pix;
  logic emit_r;
  logic live_r;
  logic [CW-1:0] rec;
  logic [CW-1:0] emi;
  logic [AW-1:0] wptr;
  logic [AW-1:0] eptr;

  logic [CW-1:0] dq;
  logic [WW-1:0] rem;
  logic tap_ok;
  logic tap_live;
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic [21:0] sq;
  logic [21:0] s;
  logic [7:0] n;
  logic [7:0] res [3];

  // effective frame size
  always_comb begin
    if (w_reg == 11'd0) w_eff = WW'(1);
    else if ({2'b0, w_reg} > 13'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(w_reg);
    if (h_reg == 11'd0) h_eff = HW'(1);
    else if ({2'b0, h_reg} > 13'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(h_reg);
    total = CW'(w_eff) * CW'(h_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg <= 11'd640;
      h_reg <= 11'd480;
    end else if (cfg_we) begin
      if (cfg_index == sem_pkg::CFG_WIDTH) w_reg <= cfg_data;
      else h_reg <= cfg_data;
    end
  end

  // frame bookkeeping at item start
  logic restart;
  logic [CW-1:0] rec_e;
  logic [CW-1:0] emi_e;
  logic [AW-1:0] wptr_e;
  logic [AW-1:0] eptr_e;
  logic full;
  logic emit_d;
  logic live_d;

  always_comb begin
    restart = emi >= total;
    rec_e = restart ? '0 : rec;
    emi_e = restart ? '0 : emi;
    wptr_e = restart ? '0 : wptr;
    eptr_e = restart ? '0 : eptr;
    full = rec_e >= total;
    if (op_r == sem_pkg::OP_PIXEL) begin
      emit_d = !full && ({1'b0, rec_e} >= ({1'b0, emi_e} + (CW + 1)'(w_eff) + (CW + 1)'(1)));
      live_d = !full;
    end else begin
      emit_d = full;
      live_d = 1'b0;
    end
    sts.emit = emit_d;
  end

  // window tap address and bounds
  logic signed [1:0] dy;
  logic signed [1:0] dx;
  logic signed [SW-1:0] wext;
  logic signed [SW-1:0] offs;
  logic signed [SW-1:0] addr_s;
  logic [AW-1:0] addr;
  logic [PW-1:0] p;
  logic ok_row;
  logic ok_col;

  always_comb begin
    dy = sem_pkg::tap_dy(cmd.tap);
    dx = sem_pkg::tap_dx(cmd.tap);
    wext = $signed(SW'(w_eff));
    if (dy < 0) offs = -wext;
    else if (dy > 0) offs = wext;
    else offs = '0;
    offs = offs + {{(SW - 2){dx[1]}}, dx};
    addr_s = $signed({2'b0, eptr}) + offs;
    if (addr_s < 0) addr_s = addr_s + SW'(DEPTH);
    else if (addr_s >= $signed(SW'(DEPTH))) addr_s = addr_s - SW'(DEPTH);
    addr = addr_s[AW-1:0];
    p = PW'(emi) + {{(PW - SW){offs[SW-1]}}, offs};
    if (dy < 0) ok_row = dq != '0;
    else if (dy > 0) ok_row = ({1'b0, dq} + (CW + 1)'(1)) < (CW + 1)'(h_eff);
    else ok_row = 1'b1;
    if (dx < 0) ok_col = rem != '0;
    else if (dx > 0) ok_col = ({1'b0, rem} + (WW + 1)'(1)) < {1'b0, w_eff};
    else ok_col = 1'b1;
  end

  logic [WW:0] rem_sh;
  logic [23:0] pxl;
  logic signed [11:0] tx [3];
  logic signed [11:0] ty [3];
  logic signed [2:0] kx;
  logic signed [2:0] ky;
  logic signed [23:0] sqa;
  logic signed [23:0] sqb;
  logic [7:0] t;
  logic [15:0] tt;
  logic [16:0] nn;
  logic [7:0] rnd_v;
  logic [CW-1:0] emi_n;
  logic last;

  always_comb begin
    rem_sh = {rem, dq[CW-1]};
    pxl = tap_live ? live_pix : rd_data;
    kx = sem_pkg::tap_kx(cmd.tap);
    ky = sem_pkg::tap_ky(cmd.tap);
    for (int c = 0; c < 3; c++) begin
      tx[c] = 12'(kx * $signed({4'b0, pxl[23 - 8 * c -: 8]}));
      ty[c] = 12'(ky * $signed({4'b0, pxl[23 - 8 * c -: 8]}));
    end
    sqa = 24'(gx[cmd.ch]) * 24'(gx[cmd.ch]);
    sqb = 24'(gy[cmd.ch]) * 24'(gy[cmd.ch]);
    t = n | (8'd1 << cmd.bitn);
    tt = 16'(t) * 16'(t);
    nn = 17'(n) * 17'(n) + 17'(n);
    if (s > sem_pkg::ROOT_SAT) rnd_v = sem_pkg::PIX_MAX;
    else if (s > 22'(nn)) rnd_v = (n == sem_pkg::PIX_MAX) ? sem_pkg::PIX_MAX : 8'(n + 8'd1);
    else rnd_v = n;
    emi_n = emi + CW'(emit_r);
    last = emit_r && (emi_n == total);
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_rd) rd_data <= mem[addr];
    if (cmd.fin && live_r) mem[wptr] <= live_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
      emi <= '0;
      wptr <= '0;
      eptr <= '0;
      emit_r <= 1'b0;
      live_r <= 1'b0;
    end else if (cmd.start) begin
      rec <= rec_e;
      emi <= emi_e;
      wptr <= wptr_e;
      eptr <= eptr_e;
      emit_r <= emit_d;
      live_r <= live_d;
    end else if (cmd.fin) begin
      if (last) begin
        rec <= '0;
        emi <= '0;
        wptr <= '0;
        eptr <= '0;
      end else begin
        emi <= emi_n;
        if (emit_r) eptr <= (eptr == AW'(DEPTH - 1)) ? '0 : eptr + AW'(1);
        if (live_r) begin
          rec <= rec + CW'(1);
          wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      live_pix <= {in_red, in_green, in_blue};
    end
    if (cmd.div_init) begin
      dq <= emi_e;
      rem <= '0;
      for (int c = 0; c < 3; c++) begin
        gx[c] <= '0;
        gy[c] <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, w_eff}) begin
        rem <= WW'(rem_sh - {1'b0, w_eff});
        dq <= {dq[CW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[WW-1:0];
        dq <= {dq[CW-2:0], 1'b0};
      end
    end
    if (cmd.tap_rd) begin
      tap_ok <= ok_row && ok_col;
      tap_live <= live_r && (p == PW'(rec));
    end
    if (cmd.tap_acc && tap_ok) begin
      for (int c = 0; c < 3; c++) begin
        gx[c] <= gx[c] + tx[c];
        gy[c] <= gy[c] + ty[c];
      end
    end
    if (cmd.sqx) sq <= 22'(sqa);
    if (cmd.sqy) s <= sq + 22'(sqb);
    if (cmd.root_init) n <= '0;
    if (cmd.root_step && ({6'b0, tt} <= s)) n <= t;
    if (cmd.rnd) res[cmd.ch] <= rnd_v;
    if (cmd.fin && emit_r) begin
      out_red <= res[0];
      out_green <= res[1];
      out_blue <= res[2];
      frame_last <= last;
    end
  end

endmodule

FILE: design/sem_controller.sv
`timescale 1ns / 1ps
module sem_controller #(
  parameter int CW = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sem_pkg::ctl_sts_t sts,
  output sem_pkg::ctl_cmd_t cmd
);

  localparam int CNT_W = ($clog2(CW + 1) > 4) ? $clog2(CW + 1) : 4;

  typedef enum logic [3:0] {
    IDLE, START, DIV, TRD, TACC, SQX, SQY, ROOT, RND, FIN
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [1:0] ch;
  logic emit_q;
  logic fin_go;

  always_comb begin
    fin_go = (state == FIN) && (!emit_q || !out_valid || !out_stall);
    in_stall = state != IDLE;
    cmd = '0;
    cmd.tap = cnt[3:0];
    cmd.ch = ch;
    cmd.bitn = cnt[2:0];
    cmd.load = (state == IDLE) && in_valid;
    cmd.start = state == START;
    cmd.div_init = (state == START) && sts.emit;
    cmd.div_step = state == DIV;
    cmd.tap_rd = state == TRD;
    cmd.tap_acc = state == TACC;
    cmd.sqx = state == SQX;
    cmd.sqy = state == SQY;
    cmd.root_init = state == SQY;
    cmd.root_step = state == ROOT;
    cmd.rnd = state == RND;
    cmd.fin = fin_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      ch <= '0;
      emit_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go && emit_q) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) state <= START;
        end
        START: begin
          emit_q <= sts.emit;
          cnt <= '0;
          ch <= '0;
          state <= sts.emit ? DIV : FIN;
        end
        DIV: begin
          if (cnt == CNT_W'(CW - 1)) begin
            cnt <= '0;
            state <= TRD;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        TRD: state <= TACC;
        TACC: begin
          if (cnt[3:0] == sem_pkg::LAST_TAP) begin
            state <= SQX;
          end else begin
            cnt <= cnt + CNT_W'(1);
            state <= TRD;
          end
        end
        SQX: state <= SQY;
        SQY: begin
          cnt <= CNT_W'(7);
          state <= ROOT;
        end
        ROOT: begin
          if (cnt == '0) state <= RND;
          else cnt <= cnt - CNT_W'(1);
        end
        RND: begin
          if (ch == sem_pkg::LAST_CH) begin
            state <= FIN;
          end else begin
            ch <= ch + 2'd1;
            state <= SQX;
          end
        end
        FIN: begin
          if (fin_go) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/sem_checker.sv
`timescale 1ns / 1ps
module sem_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [7:0] out_red,
  input logic frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(frame_last))
    else $error("output item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before item finished");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_red(out_red),
  .frame_last(frame_last)
);

FILE: tb/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_tb;

  localparam int HIST = 2050;
  localparam int DEPTH_MAX = 1024;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit last;
  } edge_px_t;

  class edge_scoreboard;
    bit [10:0] width_reg = 11'd640;
    bit [10:0] height_reg = 11'd480;
    bit [23:0] history [HIST];
    int unsigned received;
    int unsigned emitted;
    int unsigned frames;
    int unsigned errors;
    edge_px_t pending [$];

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > DEPTH_MAX) return DEPTH_MAX;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > DEPTH_MAX) return DEPTH_MAX;
      return height_reg;
    endfunction

    function void set_reg(logic idx, bit [10:0] val);
      if (idx == sem_pkg::CFG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function bit [7:0] rounded_root(int unsigned s);
      int unsigned n;
      if (s > 65280) return 8'd255;
      n = 0;
      for (int b = 128; b != 0; b >>= 1)
        if ((n | b) * (n | b) <= s) n = n | b;
      if (s > n * n + n) n++;
      return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function void predict_edge(int unsigned k, int unsigned w, int unsigned h, bit live_ok,
                               int unsigned live_idx, bit [23:0] live, bit last);
      int gx [3];
      int gy [3];
      int r, q, v;
      int unsigned p;
      bit [23:0] px;
      edge_px_t e;
      for (int c = 0; c < 3; c++) begin
        gx[c] = 0;
        gy[c] = 0;
      end
      for (int dy = -1; dy <= 1; dy++) begin
        r = int'(k / w) + dy;
        if (r < 0 || r >= int'(h)) continue;
        for (int dx = -1; dx <= 1; dx++) begin
          q = int'(k % w) + dx;
          if (q < 0 || q >= int'(w)) continue;
          p = r * w + q;
          px = (live_ok && p == live_idx) ? live : history[p % HIST];
          for (int c = 0; c < 3; c++) begin
            v = px[23 - 8 * c -: 8];
            gx[c] += dx * ((dy == 0) ? 2 : 1) * v;
            gy[c] += dy * ((dx == 0) ? 2 : 1) * v;
          end
        end
      end
      e.red = rounded_root(gx[0] * gx[0] + gy[0] * gy[0]);
      e.green = rounded_root(gx[1] * gx[1] + gy[1] * gy[1]);
      e.blue = rounded_root(gx[2] * gx[2] + gy[2] * gy[2]);
      e.last = last;
      pending.push_back(e);
    endfunction

    function void note_input(logic op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
      int unsigned w, h, total, k, live_idx;
      bit fire, live_ok;
      bit [23:0] live;
      w = eff_w();
      h = eff_h();
      total = w * h;
      k = emitted;
      fire = 0;
      live_ok = 0;
      live_idx = 0;
      live = {r, g, b};
      if (emitted >= total) begin
        received = 0;
        emitted = 0;
        k = 0;
      end
      if (op == sem_pkg::OP_PIXEL) begin
        if (received >= total) return;
        live_idx = received;
        live_ok = 1;
        fire = (live_idx >= k + w + 1);
      end else begin
        fire = (received >= total);
      end
      if (fire) begin
        emitted = k + 1;
        predict_edge(k, w, h, live_ok, live_idx, live, emitted == total);
      end
      if (live_ok) begin
        history[live_idx % HIST] = live;
        received = live_idx + 1;
      end
      if (fire && emitted == total) begin
        received = 0;
        emitted = 0;
        frames++;
      end
    endfunction

    function void check(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit last);
      edge_px_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %0d %0d %0d last %0d", r, g, b, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.red) begin
        $error("out_red expected %0d got %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("out_green expected %0d got %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("out_blue expected %0d got %0d", e.blue, b);
        errors++;
      end
      if (last !== e.last) begin
        $error("frame_last expected %0d got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic frame_last;

  edge_scoreboard sb = new();
  bit calm = 0;
  int unsigned sent = 0;

  sobel_edge_magnitude_rgb u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .in_red(in_red),
    .in_green(in_green), .in_blue(in_blue), .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .frame_last(frame_last)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check(out_red, out_green, out_blue, frame_last);
  end

  task automatic send_item(logic op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(op, r, g, b);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [10:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic bit [7:0] rand_chan(int mode);
    if (mode == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_frame();
    int unsigned start;
    int mode;
    start = sb.frames;
    mode = $urandom_range(3);
    while (sb.frames == start) begin
      if (sb.received < sb.eff_w() * sb.eff_h()) begin
        if ($urandom_range(9) == 0)
          send_item(sem_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_item(sem_pkg::OP_PIXEL, rand_chan(mode), rand_chan(mode), rand_chan(mode));
      end else begin
        if ($urandom_range(9) == 0)
          send_item(sem_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_item(sem_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic sized_frame(bit [10:0] w, bit [10:0] h);
    settle();
    write_reg(sem_pkg::CFG_WIDTH, w);
    write_reg(sem_pkg::CFG_HEIGHT, h);
    run_frame();
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame with checkerboard extremes and mixed channels
    write_reg(sem_pkg::CFG_WIDTH, 11'd3);
    write_reg(sem_pkg::CFG_HEIGHT, 11'd3);
    send_item(sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(sem_pkg::OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(sem_pkg::OP_DRAIN, 8'd255, 8'd255, 8'd255);
    send_item(sem_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd255);
    send_item(sem_pkg::OP_PIXEL, 8'd0, 8'd255, 8'd0);
    send_item(sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(sem_pkg::OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(sem_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(sem_pkg::OP_PIXEL, 8'd0, 8'd128, 8'd1);
    send_item(sem_pkg::OP_PIXEL, 8'd255, 8'd127, 8'd254);
    send_item(sem_pkg::OP_PIXEL, 8'd170, 8'd85, 8'd170);
    while (sb.received != 0) send_item(sem_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);

    // zero registers saturate to a single pixel
    sized_frame(11'd0, 11'd0);

    while (sent < 470) begin
      if ($urandom_range(9) == 0) calm = 1;
      sized_frame(11'($urandom_range(1, 8)), 11'($urandom_range(1, 6)));
      calm = 0;
    end

    sized_frame(11'd3, 11'd3);

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
